FILE: design/cpc_pkg.sv
// shared types and constants for the compressor protection controller
`timescale 1ns / 1ps
`default_nettype none

package cpc_pkg;

    localparam int unsigned IN_TDATA_W    = 32;
    localparam int unsigned OUT_TDATA_W   = 16;
    localparam int unsigned CFG_INDEX_W   = 3;
    localparam int unsigned CFG_DATA_W    = 17;
    localparam int unsigned MAX_ON_W      = 17;
    localparam int unsigned RESTART_W     = 16;
    localparam int unsigned STABLE_W      = 8;
    localparam int unsigned TEMP_W        = 8;
    localparam int unsigned STEP_W        = 8;

    localparam logic [MAX_ON_W-1:0]  MAX_ON_RESET    = 17'd90000;
    localparam logic [RESTART_W-1:0] RESTART_RESET   = 16'd4800;
    localparam logic [STABLE_W-1:0]  STABLE_RESET    = 8'd100;
    localparam logic [RESTART_W-1:0] SHORTCUT_RESET  = 16'd3000;
    localparam logic [TEMP_W-1:0]    AMBIENT_RESET   = 8'd30;
    localparam logic [STEP_W-1:0]    INIT_ALLOW_STEP = 8'd5;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_MAX_ON    = 3'd0,
        REG_RESTART   = 3'd1,
        REG_STABLE    = 3'd2,
        REG_SHORTCUT  = 3'd3,
        REG_AMBIENT   = 3'd4
    } cfg_index_t;

    // cold mode gas-valve init sequence
    typedef enum logic [1:0] {
        COLD_IDLE       = 2'd0,
        COLD_VALVE_WAIT = 2'd1,
        COLD_READY      = 2'd2
    } cold_phase_t;

    typedef struct packed {
        logic [MAX_ON_W-1:0]  max_on_ticks;
        logic [RESTART_W-1:0] restart_delay_ticks;
        logic [STABLE_W-1:0]  stable_ticks;
        logic [RESTART_W-1:0] shortcut_remaining_ticks;
        logic [TEMP_W-1:0]    ambient_limit;
    } cfg_t;

    typedef struct packed {
        logic              cold_go;
        logic              ice_make_go;
        logic              in_making_phase;
        logic              in_standby_phase;
        logic [STEP_W-1:0] init_step;
        logic              make_time_left;
        logic              ice_init_request;
        logic              ice_mode;
        logic [TEMP_W-1:0] ambient_temp;
        logic              valve_at_cold;
        logic              both_disabled;
        logic              external_off;
    } tick_in_t;

    typedef struct packed {
        logic compressor_drive;
        logic compressor_stable;
        logic restart_wait;
        logic max_on_cut;
        logic valve_to_cold_cmd;
        logic cold_request_on;
        logic ice_request_on;
        logic init_request_on;
        logic error_off;
    } tick_out_t;

endpackage

`default_nettype wire

FILE: design/cpc_cfg_regs.sv
// configuration register file with write-only port
`timescale 1ns / 1ps
`default_nettype none

module cpc_cfg_regs
    import cpc_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
    output cfg_t                        cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MAX_ON:   cfg_next.max_on_ticks = cfg_wdata[MAX_ON_W-1:0];
                REG_RESTART:  cfg_next.restart_delay_ticks = cfg_wdata[RESTART_W-1:0];
                REG_STABLE:   cfg_next.stable_ticks = cfg_wdata[STABLE_W-1:0];
                REG_SHORTCUT: cfg_next.shortcut_remaining_ticks = cfg_wdata[RESTART_W-1:0];
                REG_AMBIENT:  cfg_next.ambient_limit = cfg_wdata[TEMP_W-1:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_on_ticks             <= MAX_ON_RESET;
            cfg_reg.restart_delay_ticks      <= RESTART_RESET;
            cfg_reg.stable_ticks             <= STABLE_RESET;
            cfg_reg.shortcut_remaining_ticks <= SHORTCUT_RESET;
            cfg_reg.ambient_limit            <= AMBIENT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

FILE: design/cpc_tick_logic.sv
// per-tick decision logic and protection timers
`timescale 1ns / 1ps
`default_nettype none

module cpc_tick_logic
    import cpc_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     step,
    input  wire tick_in_t tick_in,
    input  wire cfg_t     cfg,
    output tick_out_t     tick_out
);

    logic                 drive_reg, drive_next;
    logic [MAX_ON_W-1:0]  on_time_reg, on_time_next;
    logic                 cutoff_reg, cutoff_next;
    logic [RESTART_W-1:0] restart_cnt_reg, restart_cnt_next;
    logic                 restart_flag_reg, restart_flag_next;
    logic [STABLE_W-1:0]  stable_cnt_reg, stable_cnt_next;
    logic                 stable_flag_next;
    cold_phase_t          phase_reg, phase_next;

    logic [MAX_ON_W:0]    on_inc;
    logic [STABLE_W:0]    stable_inc;
    logic                 valve_cmd;
    logic                 cold_req;
    logic                 ice_req;
    logic                 init_req;
    logic                 off_reason;
    logic                 shortcut;

    // cold mode request behind the valve init sequence
    always_comb
    begin
        phase_next = phase_reg;
        valve_cmd  = 1'b0;
        cold_req   = 1'b0;
        if (!tick_in.cold_go)
        begin
            phase_next = COLD_IDLE;
        end
        else if (!restart_flag_reg)
        begin
            unique case (phase_reg)
                COLD_IDLE:
                begin
                    valve_cmd  = 1'b1;
                    phase_next = COLD_VALVE_WAIT;
                end
                COLD_VALVE_WAIT:
                begin
                    if (tick_in.valve_at_cold)
                        phase_next = COLD_READY;
                end
                COLD_READY:
                begin
                    cold_req = 1'b1;
                end
                default:
                begin
                    phase_next = COLD_IDLE;
                end
            endcase
            if (drive_reg)
                cold_req = 1'b1;
        end
    end

    assign ice_req  = tick_in.in_making_phase & tick_in.ice_make_go;
    assign init_req = (tick_in.init_step == INIT_ALLOW_STEP) & tick_in.make_time_left
                      & tick_in.ice_init_request;

    // max-on cutoff, driven by the previous drive value
    assign on_inc = {1'b0, on_time_reg} + {{MAX_ON_W{1'b0}}, 1'b1};

    always_comb
    begin
        on_time_next = '0;
        cutoff_next  = 1'b0;
        if (drive_reg)
        begin
            if (on_inc >= {1'b0, cfg.max_on_ticks})
            begin
                on_time_next = cfg.max_on_ticks;
                cutoff_next  = tick_in.in_standby_phase | cutoff_reg;
            end
            else
            begin
                on_time_next = on_inc[MAX_ON_W-1:0];
            end
        end
    end

    // restart delay with cold-ambient shortcut in ice mode
    assign shortcut = tick_in.ice_mode && (tick_in.ambient_temp < cfg.ambient_limit)
                      && (restart_cnt_reg <= cfg.shortcut_remaining_ticks);

    always_comb
    begin
        restart_cnt_next  = restart_cnt_reg;
        restart_flag_next = 1'b0;
        if (drive_reg)
        begin
            restart_cnt_next = cfg.restart_delay_ticks;
        end
        else if (restart_cnt_reg != '0)
        begin
            restart_cnt_next  = shortcut ? '0 : restart_cnt_reg - 1'b1;
            restart_flag_next = 1'b1;
        end
    end

    assign off_reason = restart_flag_next | cutoff_next | tick_in.both_disabled
                        | tick_in.external_off;
    assign drive_next = !off_reason && (cold_req || ice_req || init_req);

    // stability, driven by the new drive value
    assign stable_inc = {1'b0, stable_cnt_reg} + {{STABLE_W{1'b0}}, 1'b1};

    always_comb
    begin
        stable_cnt_next  = '0;
        stable_flag_next = 1'b1;
        if (drive_next)
        begin
            if (stable_inc >= {1'b0, cfg.stable_ticks})
            begin
                stable_cnt_next = cfg.stable_ticks;
            end
            else
            begin
                stable_cnt_next  = stable_inc[STABLE_W-1:0];
                stable_flag_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drive_reg        <= 1'b0;
            on_time_reg      <= '0;
            cutoff_reg       <= 1'b0;
            restart_cnt_reg  <= '0;
            restart_flag_reg <= 1'b0;
            stable_cnt_reg   <= '0;
            phase_reg        <= COLD_IDLE;
        end
        else if (step)
        begin
            drive_reg        <= drive_next;
            on_time_reg      <= on_time_next;
            cutoff_reg       <= cutoff_next;
            restart_cnt_reg  <= restart_cnt_next;
            restart_flag_reg <= restart_flag_next;
            stable_cnt_reg   <= stable_cnt_next;
            phase_reg        <= phase_next;
        end
    end

    assign tick_out.compressor_drive  = drive_next;
    assign tick_out.compressor_stable = stable_flag_next;
    assign tick_out.restart_wait      = restart_flag_next;
    assign tick_out.max_on_cut        = cutoff_next;
    assign tick_out.valve_to_cold_cmd = valve_cmd;
    assign tick_out.cold_request_on   = cold_req;
    assign tick_out.ice_request_on    = ice_req;
    assign tick_out.init_request_on   = init_req;
    assign tick_out.error_off         = tick_in.both_disabled;

    // an active restart delay never lets the compressor start
    assert property (@(posedge clk) disable iff (!rst_n)
        (step && restart_flag_next) |=> !drive_reg)
        else $error("drive set while restart delay active");

    // an off tick clears the max-on timer and cutoff
    assert property (@(posedge clk) disable iff (!rst_n)
        (step && !drive_reg) |=> (on_time_reg == '0 && !cutoff_reg))
        else $error("max-on timer not cleared while off");

    // a running tick reloads the restart delay
    assert property (@(posedge clk) disable iff (!rst_n)
        (step && drive_reg) |=> (restart_cnt_reg == $past(cfg.restart_delay_ticks)
                                 && !restart_flag_reg))
        else $error("restart delay not reloaded while running");

    // the valve pulse only leaves the idle phase
    assert property (@(posedge clk) disable iff (!rst_n)
        (step && valve_cmd) |=> (phase_reg == COLD_VALVE_WAIT))
        else $error("valve pulse without phase advance");

endmodule

`default_nettype wire

FILE: design/compressor_protection_controller.sv
// top level of the compressor protection controller
`timescale 1ns / 1ps
`default_nettype none

// compressor protection controller: each stream transfer on the s_axis side is one
// control tick (nominally 100 ms) and yields exactly one result transfer on the
// m_axis side. the block decides the compressor drive from the on-requests (cold
// mode behind a three-step gas-valve init, ice making, ice init) and the
// off-reasons (restart delay, max-on cutoff, both-disabled error, external off).
// a tick is registered in the input register, then the decision logic updates
// the protection timers and loads the result register; with m_axis_tready high
// the block takes one tick per clock, and the result register decouples the
// sides, so a new tick is taken while a result still waits. configuration
// registers are written through cfg_we/cfg_index/cfg_wdata and should only
// change while no tick is in flight. writes to indexes above four are ignored.

module compressor_protection_controller
    import cpc_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,

    // configuration write port
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,

    // tick input
    input  wire logic                   s_axis_tvalid,
    output      logic                   s_axis_tready,
    // [0] cold_go, [1] ice_make_go, [2] in_making_phase, [3] in_standby_phase,
    // [11:4] init_step, [12] make_time_left, [13] ice_init_request, [14] ice_mode,
    // [22:15] ambient_temp, [23] valve_at_cold, [24] both_disabled,
    // [25] external_off, [31:26] zero
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,

    // result output
    output      logic                   m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // [0] compressor_drive, [1] compressor_stable, [2] restart_wait,
    // [3] max_on_cut, [4] valve_to_cold_cmd, [5] cold_request_on,
    // [6] ice_request_on, [7] init_request_on, [8] error_off, [15:9] zero
    output      logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    cfg_t      cfg;
    tick_in_t  in_item_reg, in_item_next;
    logic      in_valid_reg;
    tick_out_t tick_out;
    tick_out_t res_reg;
    logic      res_valid_reg;
    logic      advance;
    logic      s_xfer;

    cpc_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // unpack the input transfer, first field at bit 0
    always_comb
    begin
        in_item_next.cold_go          = s_axis_tdata[0];
        in_item_next.ice_make_go      = s_axis_tdata[1];
        in_item_next.in_making_phase  = s_axis_tdata[2];
        in_item_next.in_standby_phase = s_axis_tdata[3];
        in_item_next.init_step        = s_axis_tdata[11:4];
        in_item_next.make_time_left   = s_axis_tdata[12];
        in_item_next.ice_init_request = s_axis_tdata[13];
        in_item_next.ice_mode         = s_axis_tdata[14];
        in_item_next.ambient_temp     = s_axis_tdata[22:15];
        in_item_next.valve_at_cold    = s_axis_tdata[23];
        in_item_next.both_disabled    = s_axis_tdata[24];
        in_item_next.external_off     = s_axis_tdata[25];
    end

    // the tick moves from the input register to the result register when the
    // result slot is free or being drained this cycle
    assign advance       = in_valid_reg && (!res_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_xfer        = s_axis_tvalid && s_axis_tready;

    cpc_tick_logic u_tick_logic (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (advance),
        .tick_in  (in_item_reg),
        .cfg      (cfg),
        .tick_out (tick_out)
    );

    // control state of the two-stage handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_xfer)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                res_valid_reg <= 1'b1;
            else if (m_axis_tready)
                res_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_xfer)
            in_item_reg <= in_item_next;
        if (advance)
            res_reg <= tick_out;
    end

    assign m_axis_tvalid = res_valid_reg;
    assign m_axis_tdata  = {7'd0,
                            res_reg.error_off,
                            res_reg.init_request_on,
                            res_reg.ice_request_on,
                            res_reg.cold_request_on,
                            res_reg.valve_to_cold_cmd,
                            res_reg.max_on_cut,
                            res_reg.restart_wait,
                            res_reg.compressor_stable,
                            res_reg.compressor_drive};

endmodule

`default_nettype wire

FILE: tb/sv/compressor_protection_controller_tb.sv
// testbench for the compressor protection controller: tick stream against a local predictor
`timescale 1ns / 1ps

module compressor_protection_controller_tb
    import cpc_pkg::*;
;

    // idle cycles without any transfer before the run is declared hung
    localparam int unsigned HANG_LIMIT = 4000;
    // settle time after the last result
    localparam int unsigned SETTLE_CYCLES = 6;
    localparam int unsigned TICK_IN_W = $bits(tick_in_t);

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    cfg_index_t             cfg_index = REG_MAX_ON;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    compressor_protection_controller u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // predictor state: settings as the block holds them, plus the
    // protection timers and the cold init phase
    // ------------------------------------------------------------------
    cfg_t model_cfg = '{
        max_on_ticks:             MAX_ON_RESET,
        restart_delay_ticks:      RESTART_RESET,
        stable_ticks:             STABLE_RESET,
        shortcut_remaining_ticks: SHORTCUT_RESET,
        ambient_limit:            AMBIENT_RESET
    };

    logic        drive_now = 1'b0;
    int unsigned run_ticks = 0;       // max-on counter, may step one past 17 bits
    logic        cutoff_now = 1'b0;
    int unsigned delay_left = 0;      // restart delay still to wait
    logic        delay_active = 1'b0;
    int unsigned stable_run = 0;
    logic        stable_now = 1'b0;
    logic [1:0]  cold_phase = COLD_IDLE;

    tick_out_t expected_ticks[$];     // predicted results in order of the input transfers
    int unsigned fail_count = 0;

    // bookkeeping for the sender and the receiver
    int unsigned burst_left = 0;
    int unsigned stall_left = 0;
    int unsigned stall_mode = 0;
    int unsigned idle_cycles = 0;
    logic        cold_hold = 1'b0;
    logic        ice_hold = 1'b0;

    // one control tick: updates the local state, returns the result fields
    function automatic tick_out_t predict_tick(input tick_in_t t);
        tick_out_t r;
        logic      was_on;
        r = '0;
        was_on = drive_now;

        // cold mode request behind the gas-valve init sequence
        if (t.cold_go)
        begin
            if (!delay_active)
            begin
                case (cold_phase)
                    COLD_IDLE:
                    begin
                        r.valve_to_cold_cmd = 1'b1;
                        cold_phase = COLD_VALVE_WAIT;
                    end
                    COLD_VALVE_WAIT:
                    begin
                        if (t.valve_at_cold)
                            cold_phase = COLD_READY;
                    end
                    COLD_READY:
                        r.cold_request_on = 1'b1;
                    default:
                        cold_phase = COLD_IDLE;
                endcase
                // already running: keep the cold request in any phase
                if (was_on)
                    r.cold_request_on = 1'b1;
            end
        end
        else
            cold_phase = COLD_IDLE;

        r.ice_request_on = t.in_making_phase & t.ice_make_go;
        r.init_request_on = (t.init_step == INIT_ALLOW_STEP && t.make_time_left) ?
                            t.ice_init_request : 1'b0;

        // max-on cutoff, driven by the previous drive value
        if (!was_on)
        begin
            run_ticks = 0;
            cutoff_now = 1'b0;
        end
        else
        begin
            run_ticks++;
            if (run_ticks >= int'(model_cfg.max_on_ticks))
            begin
                run_ticks = 32'(model_cfg.max_on_ticks);
                if (t.in_standby_phase)
                    cutoff_now = 1'b1;
            end
            else
                cutoff_now = 1'b0;
        end

        // restart delay, with the cold-ambient shortcut in ice mode
        if (was_on)
        begin
            delay_left = 32'(model_cfg.restart_delay_ticks);
            delay_active = 1'b0;
        end
        else if (delay_left > 0)
        begin
            if (t.ice_mode && t.ambient_temp < model_cfg.ambient_limit &&
                delay_left <= int'(model_cfg.shortcut_remaining_ticks))
                delay_left = 1;
            delay_left--;
            delay_active = 1'b1;
        end
        else
            delay_active = 1'b0;

        r.error_off = t.both_disabled;
        r.restart_wait = delay_active;
        r.max_on_cut = cutoff_now;
        drive_now = !(delay_active | cutoff_now | t.both_disabled | t.external_off) &&
                    (r.cold_request_on | r.ice_request_on | r.init_request_on);
        r.compressor_drive = drive_now;

        // stability follows the new drive value
        if (!drive_now)
        begin
            stable_run = 0;
            stable_now = 1'b1;
        end
        else
        begin
            stable_run++;
            if (stable_run >= int'(model_cfg.stable_ticks))
            begin
                stable_run = 32'(model_cfg.stable_ticks);
                stable_now = 1'b1;
            end
            else
                stable_now = 1'b0;
        end
        r.compressor_stable = stable_now;
        return r;
    endfunction

    // fields packed from the lowest bit up, as on s_axis_tdata
    function automatic logic [IN_TDATA_W-1:0] tick_to_tdata(input tick_in_t t);
        logic [IN_TDATA_W-1:0] d;
        d = '0;
        d[0]     = t.cold_go;
        d[1]     = t.ice_make_go;
        d[2]     = t.in_making_phase;
        d[3]     = t.in_standby_phase;
        d[11:4]  = t.init_step;
        d[12]    = t.make_time_left;
        d[13]    = t.ice_init_request;
        d[14]    = t.ice_mode;
        d[22:15] = t.ambient_temp;
        d[23]    = t.valve_at_cold;
        d[24]    = t.both_disabled;
        d[25]    = t.external_off;
        return d;
    endfunction

    // result fields in m_axis_tdata order, padding bits expected zero
    function automatic logic [OUT_TDATA_W-1:0] result_to_tdata(input tick_out_t r);
        logic [OUT_TDATA_W-1:0] d;
        d = '0;
        d[0] = r.compressor_drive;
        d[1] = r.compressor_stable;
        d[2] = r.restart_wait;
        d[3] = r.max_on_cut;
        d[4] = r.valve_to_cold_cmd;
        d[5] = r.cold_request_on;
        d[6] = r.ice_request_on;
        d[7] = r.init_request_on;
        d[8] = r.error_off;
        return d;
    endfunction

    function automatic string result_field(input int unsigned bit_pos);
        case (bit_pos)
            0: return "compressor_drive";
            1: return "compressor_stable";
            2: return "restart_wait";
            3: return "max_on_cut";
            4: return "valve_to_cold_cmd";
            5: return "cold_request_on";
            6: return "ice_request_on";
            7: return "init_request_on";
            8: return "error_off";
            default: return "padding";
        endcase
    endfunction

    // ------------------------------------------------------------------
    // sender: bursts of random length, random gaps in between
    // ------------------------------------------------------------------
    task automatic send_tick(input tick_in_t t);
        int unsigned gap;
        if (burst_left == 0)
        begin
            // a quarter of the bursts follow the previous one back to back
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= tick_to_tdata(t);
        do
            @(posedge clk);
        while (!s_axis_tready);
        // transfer taken at this edge
        expected_ticks.push_back(predict_tick(t));
        burst_left--;
        @(negedge clk);
    endtask

    // hold the input side idle until every predicted result has come back
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (expected_ticks.size() != 0)
            @(negedge clk);
    endtask

    // write all five registers back to back while the block is idle
    task automatic load_settings(input cfg_t c);
        drain_results();
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_MAX_ON;
        cfg_wdata <= CFG_DATA_W'(c.max_on_ticks);
        @(negedge clk);
        cfg_index <= REG_RESTART;
        cfg_wdata <= CFG_DATA_W'(c.restart_delay_ticks);
        @(negedge clk);
        cfg_index <= REG_STABLE;
        cfg_wdata <= CFG_DATA_W'(c.stable_ticks);
        @(negedge clk);
        cfg_index <= REG_SHORTCUT;
        cfg_wdata <= CFG_DATA_W'(c.shortcut_remaining_ticks);
        @(negedge clk);
        cfg_index <= REG_AMBIENT;
        cfg_wdata <= CFG_DATA_W'(c.ambient_limit);
        @(negedge clk);
        cfg_we <= 1'b0;
        model_cfg = c;
    endtask

    // mostly plausible ticks: held demand flags, rare off-reasons,
    // ambient close to the limit; one in eight is pure noise
    function automatic tick_in_t random_tick();
        tick_in_t             t;
        logic [TICK_IN_W-1:0] noise;
        int                   amb;
        noise = TICK_IN_W'($urandom);
        if ($urandom_range(0, 7) == 0)
            return noise;
        t = '0;
        if ($urandom_range(0, 9) == 0)
            cold_hold = ~cold_hold;
        if ($urandom_range(0, 11) == 0)
            ice_hold = ~ice_hold;
        t.cold_go          = cold_hold;
        t.ice_make_go      = ice_hold;
        t.in_making_phase  = ($urandom_range(0, 3) != 0);
        t.in_standby_phase = ($urandom_range(0, 2) == 0);
        t.init_step        = ($urandom_range(0, 3) != 0) ? INIT_ALLOW_STEP : 8'($urandom);
        t.make_time_left   = 1'($urandom_range(0, 1));
        t.ice_init_request = ($urandom_range(0, 3) == 0);
        t.ice_mode         = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 1) == 0)
        begin
            amb = int'(model_cfg.ambient_limit) + int'($urandom_range(0, 3)) - 2;
            if (amb < 0)
                amb = 0;
            if (amb > 255)
                amb = 255;
            t.ambient_temp = 8'(amb);
        end
        else
            t.ambient_temp = 8'($urandom);
        t.valve_at_cold = 1'($urandom_range(0, 1));
        t.both_disabled = ($urandom_range(0, 19) == 0);
        t.external_off  = ($urandom_range(0, 19) == 0);
        return t;
    endfunction

    // ------------------------------------------------------------------
    // receiver: stall pattern that switches at random among four modes
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(16, 80);
        end
        else
            stall_left--;
        case (stall_mode)
            0: m_axis_tready <= 1'b1;                          // no stalls
            1: m_axis_tready <= ($urandom_range(0, 3) != 0);  // light stalls
            2: m_axis_tready <= ~m_axis_tready;               // alternating
            default: m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // compare each result transfer with the oldest prediction
    always @(posedge clk)
    begin : result_check
        tick_out_t              want;
        logic [OUT_TDATA_W-1:0] want_bits;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_ticks.size() == 0)
            begin
                $display("%0t: result with nothing expected, actual %h", $time, m_axis_tdata);
                fail_count++;
            end
            else
            begin
                want = expected_ticks.pop_front();
                want_bits = result_to_tdata(want);
                for (int unsigned i = 0; i < OUT_TDATA_W; i++)
                begin
                    if (m_axis_tdata[i[3:0]] !== want_bits[i[3:0]])
                    begin
                        $display("%0t: %s expected %b actual %b", $time, result_field(i),
                                 want_bits[i[3:0]], m_axis_tdata[i[3:0]]);
                        fail_count++;
                    end
                end
            end
        end
    end

    // hang detection: cycles in a row without any transfer
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= HANG_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // cold init sequence, max-on cutoff in standby, restart delay with
    // the shortcut, the other requests and off-reasons, field extremes
    task automatic test_directed_sequence();
        tick_in_t t;
        load_settings('{max_on_ticks: 17'd4, restart_delay_ticks: 16'd8, stable_ticks: 8'd3,
                        shortcut_remaining_ticks: 16'd4, ambient_limit: 8'd30});
        t = '0;
        t.cold_go = 1'b1;
        send_tick(t);               // valve pulse, wait for the valve
        send_tick(t);               // valve not there yet
        t.valve_at_cold = 1'b1;
        send_tick(t);               // valve reports cold
        t.valve_at_cold = 1'b0;
        send_tick(t);               // cold request granted, drive on
        repeat (5) send_tick(t);    // max-on saturates, no standby so no cutoff
        t.in_standby_phase = 1'b1;
        send_tick(t);               // cutoff at saturation in standby
        t.in_standby_phase = 1'b0;
        t.ice_mode = 1'b1;
        t.ambient_temp = 8'd0;
        repeat (5) send_tick(t);    // restart delay blocks cold, shortcut ends it
        send_tick(t);               // delay over, cold request still held off
        t = '0;
        send_tick(t);               // cold dropped, phase back to idle
        t.ice_make_go = 1'b1;
        t.in_making_phase = 1'b1;
        t.ambient_temp = 8'hFF;
        send_tick(t);               // ice request
        t = '0;
        t.init_step = INIT_ALLOW_STEP;
        t.make_time_left = 1'b1;
        t.ice_init_request = 1'b1;
        send_tick(t);               // init request at the allowed step
        t.init_step = 8'hFF;
        send_tick(t);               // wrong step
        t.init_step = 8'h00;
        send_tick(t);
        t.init_step = INIT_ALLOW_STEP;
        t.both_disabled = 1'b1;
        send_tick(t);               // error off
        t.both_disabled = 1'b0;
        t.external_off = 1'b1;
        send_tick(t);               // external off
        t = '1;
        send_tick(t);               // every field at its top value
    endtask

    // zero max-on and zero stable take effect at once
    task automatic test_zero_limits();
        tick_in_t t;
        load_settings('{max_on_ticks: '0, restart_delay_ticks: '0, stable_ticks: '0,
                        shortcut_remaining_ticks: '0, ambient_limit: '0});
        t = '0;
        t.ice_make_go = 1'b1;
        t.in_making_phase = 1'b1;
        repeat (4) send_tick(t);
        t.in_standby_phase = 1'b1;
        repeat (3) send_tick(t);
        t.in_standby_phase = 1'b0;
        repeat (3) send_tick(t);
        t.cold_go = 1'b1;
        t.valve_at_cold = 1'b1;
        repeat (3) send_tick(t);
    endtask

    task automatic run_random_ticks(input int unsigned count);
        for (int unsigned i = 0; i < count; i++)
            send_tick(random_tick());
    endtask

    // register extremes, top and bottom
    task automatic test_extreme_settings();
        load_settings('{max_on_ticks: 17'h1FFFF, restart_delay_ticks: 16'hFFFF,
                        stable_ticks: 8'hFF, shortcut_remaining_ticks: 16'hFFFF,
                        ambient_limit: 8'hFF});
        run_random_ticks(50);
        load_settings('{max_on_ticks: 17'd1, restart_delay_ticks: 16'd1, stable_ticks: 8'd1,
                        shortcut_remaining_ticks: 16'd0, ambient_limit: 8'd0});
        run_random_ticks(50);
    endtask

    // short timers so cutoff, delay and stability all cycle often
    task automatic test_random_settings();
        cfg_t c;
        for (int unsigned phase = 0; phase < 6; phase++)
        begin
            c.max_on_ticks             = 17'($urandom_range(1, 40));
            c.restart_delay_ticks      = 16'($urandom_range(0, 25));
            c.stable_ticks             = 8'($urandom_range(1, 12));
            c.shortcut_remaining_ticks = 16'($urandom_range(0, 25));
            c.ambient_limit            = 8'($urandom);
            load_settings(c);
            run_random_ticks(40);
            drain_results();        // input side waits for every result
            run_random_ticks(40);
        end
    endtask

    initial
    begin
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed_sequence();
        test_zero_limits();
        test_extreme_settings();
        test_random_settings();

        drain_results();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
